// ----- src/lcvm_pkg.sv -----
// shared types and constants of the line clip and viewport map block
package lcvm_pkg;

	localparam int COORD_W   = 16;
	localparam int PARAM_F   = 16;
	localparam int DIV_STEPS = (PARAM_F > COORD_W) ? PARAM_F : COORD_W;
	localparam int NLANE     = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   delta_t;
	typedef logic signed [PARAM_F+1:0] ratio_t;
	typedef logic [PARAM_F:0]          tpar_t;

	localparam ratio_t T_ONE = ratio_t'(64'd1 << PARAM_F);

	typedef struct packed {
		logic [COORD_W-1:0]   rem;
		logic [DIV_STEPS-1:0] num;
		logic [DIV_STEPS-1:0] quo;
		logic [COORD_W-1:0]   dvs;
	} lane_t;

	typedef struct packed {
		coord_t                  x0;
		coord_t                  y0;
		delta_t                  dx;
		delta_t                  dy;
		logic                    rej;
		logic [NLANE-1:0]        frc;
		ratio_t [NLANE-1:0]      fval;
	} edge_side_t;

	localparam int SIDE_W = $bits(edge_side_t);

	typedef struct packed {
		logic                valid;
		lane_t [NLANE-1:0]   lane;
		logic [SIDE_W-1:0]   side;
	} div_item_t;

	typedef enum logic [2:0] {
		REG_WIN_LEFT   = 3'd0,
		REG_WIN_BOTTOM = 3'd1,
		REG_WIN_RIGHT  = 3'd2,
		REG_WIN_TOP    = 3'd3,
		REG_VIEW_LEFT  = 3'd4,
		REG_VIEW_BOTTOM = 3'd5,
		REG_VIEW_RIGHT = 3'd6,
		REG_VIEW_TOP   = 3'd7
	} cfg_reg_e;

endpackage

// ----- src/lcvm_div_cell.sv -----
// one restoring division step for all lanes of an item, registered
module lcvm_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv_in,
	output logic                adv_out,
	input  lcvm_pkg::div_item_t d_in,
	output lcvm_pkg::div_item_t d_out
);
	import lcvm_pkg::*;

	div_item_t          nxt_c;
	div_item_t          data_q;
	logic               valid_q;
	logic [COORD_W:0]   trial [NLANE];
	logic [COORD_W:0]   diff  [NLANE];
	logic               ge    [NLANE];

	always_comb begin
		nxt_c = d_in;
		for (int i = 0; i < NLANE; i++) begin
			trial[i] = {d_in.lane[i].rem, d_in.lane[i].num[DIV_STEPS-1]};
			diff[i]  = trial[i] - {1'b0, d_in.lane[i].dvs};
			ge[i]    = trial[i] >= {1'b0, d_in.lane[i].dvs};
			nxt_c.lane[i].rem = ge[i] ? diff[i][COORD_W-1:0] : trial[i][COORD_W-1:0];
			nxt_c.lane[i].num = {d_in.lane[i].num[DIV_STEPS-2:0], 1'b0};
			nxt_c.lane[i].quo = {d_in.lane[i].quo[DIV_STEPS-2:0], ge[i]};
		end
	end

	assign adv_out = !valid_q || adv_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_out) begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			data_q <= nxt_c;
		end
	end

	always_comb begin
		d_out       = data_q;
		d_out.valid = valid_q;
	end

endmodule

// ----- src/lcvm_div_row.sv -----
// row of division cells, one quotient bit per cell
module lcvm_div_row (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv_in,
	output logic                adv_out,
	input  lcvm_pkg::div_item_t d_in,
	output lcvm_pkg::div_item_t d_out
);
	import lcvm_pkg::*;

	div_item_t link [DIV_STEPS+1];
	logic      adv  [DIV_STEPS+1];

	assign link[0]        = d_in;
	assign adv[DIV_STEPS] = adv_in;
	assign adv_out        = adv[0];
	assign d_out          = link[DIV_STEPS];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
		lcvm_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv_in  (adv[g+1]),
			.adv_out (adv[g]),
			.d_in    (link[g]),
			.d_out   (link[g+1])
		);
	end

endmodule

// ----- src/line_clip_viewport_map.sv -----
// top level: segment clipping against the window and mapping to the viewport
//
// Clips one segment per cycle, unless out_stall holds the pipeline, against
// the window with the Liang-Barsky edge tests and maps the clipped endpoints
// into the viewport, saturated to the Q12.4 range; an invisible segment
// returns visible low and all coordinates zero. Throughput is one item per
// clock while out_stall is low. An item passes 38 register stages: one setup
// stage loaded at acceptance, a row of 16 division cells for the edge ratios,
// four stages for the parameter range, interpolation and scaling products, a
// second row of 16 division cells for the viewport scaling, and the output
// register. Stalls collapse bubbles stage by stage.
// Configuration writes are always ready and take effect at once; write them
// only while no item is in flight.
module line_clip_viewport_map (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lcvm_pkg::coord_t start_x,
	input  lcvm_pkg::coord_t start_y,
	input  lcvm_pkg::coord_t end_x,
	input  lcvm_pkg::coord_t end_y,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             visible,
	output lcvm_pkg::coord_t view_start_x,
	output lcvm_pkg::coord_t view_start_y,
	output lcvm_pkg::coord_t view_end_x,
	output lcvm_pkg::coord_t view_end_y,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  lcvm_pkg::coord_t cfg_data
);
	import lcvm_pkg::*;

	localparam int PROD_W = PARAM_F + COORD_W + 3;
	localparam int SUM_W  = DIV_STEPS + 3;

	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [COORD_W+1:0] wide_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	localparam sum_t SAT_HI = sum_t'((64'sd1 <<< (COORD_W-1)) - 64'sd1);
	localparam sum_t SAT_LO = -SAT_HI - sum_t'(1);
	localparam prod_t HALF  = prod_t'(64'sd1 <<< (PARAM_F-1));

	typedef struct packed {
		delta_t d;
		logic   rej;
		lane_t  le;
		lane_t  ll;
		logic   fe;
		logic   fl;
		ratio_t ve;
		ratio_t vl;
	} axis_setup_t;

	// configuration

	coord_t win_left_q, win_bottom_q, win_right_q, win_top_q;
	coord_t view_left_q, view_bottom_q, view_right_q, view_top_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q    <= coord_t'(800);
			win_bottom_q  <= coord_t'(800);
			win_right_q   <= coord_t'(2400);
			win_top_q     <= coord_t'(2400);
			view_left_q   <= coord_t'(3200);
			view_bottom_q <= coord_t'(3200);
			view_right_q  <= coord_t'(4800);
			view_top_q    <= coord_t'(4800);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_WIN_LEFT:    win_left_q    <= cfg_data;
				REG_WIN_BOTTOM:  win_bottom_q  <= cfg_data;
				REG_WIN_RIGHT:   win_right_q   <= cfg_data;
				REG_WIN_TOP:     win_top_q     <= cfg_data;
				REG_VIEW_LEFT:   view_left_q   <= cfg_data;
				REG_VIEW_BOTTOM: view_bottom_q <= cfg_data;
				REG_VIEW_RIGHT:  view_right_q  <= cfg_data;
				REG_VIEW_TOP:    view_top_q    <= cfg_data;
				default:         win_left_q    <= win_left_q;
			endcase
		end
	end

	// per axis: index 0 is x, index 1 is y
	coord_t             wmin_a [2];
	coord_t             vmin_a [2];
	delta_t             ww_a   [2];
	delta_t             vw_a   [2];
	delta_t             nvw_a  [2];
	logic [COORD_W-1:0] avw_a  [2];

	always_comb begin
		wmin_a[0] = win_left_q;
		wmin_a[1] = win_bottom_q;
		vmin_a[0] = view_left_q;
		vmin_a[1] = view_bottom_q;
		ww_a[0]   = delta_t'(win_right_q) - delta_t'(win_left_q);
		ww_a[1]   = delta_t'(win_top_q) - delta_t'(win_bottom_q);
		vw_a[0]   = delta_t'(view_right_q) - delta_t'(view_left_q);
		vw_a[1]   = delta_t'(view_top_q) - delta_t'(view_bottom_q);
		for (int a = 0; a < 2; a++) begin
			nvw_a[a] = -vw_a[a];
			avw_a[a] = (vw_a[a] < 0) ? nvw_a[a][COORD_W-1:0] : vw_a[a][COORD_W-1:0];
		end
	end

	// edge setup

	function automatic lane_t mk_lane(input delta_t n, input logic [COORD_W-1:0] ad);
		logic [COORD_W+DIV_STEPS-1:0] dividend;
		lane_t                        l;
		dividend = (COORD_W+DIV_STEPS)'(n[COORD_W-1:0]) << PARAM_F;
		l.rem    = dividend[COORD_W+DIV_STEPS-1 -: COORD_W];
		l.num    = dividend[DIV_STEPS-1:0];
		l.quo    = '0;
		l.dvs    = ad;
		return l;
	endfunction

	function automatic axis_setup_t axis_setup(input coord_t p0, input coord_t p1,
			input coord_t wmin, input coord_t wmax);
		delta_t             d;
		delta_t             nd;
		delta_t             ne;
		delta_t             nl;
		delta_t             sad;
		logic [COORD_W-1:0] ad;
		axis_setup_t        r;
		d   = delta_t'(p1) - delta_t'(p0);
		nd  = -d;
		ad  = (d < 0) ? nd[COORD_W-1:0] : d[COORD_W-1:0];
		sad = delta_t'({1'b0, ad});
		if (d > 0) begin
			ne = delta_t'(wmin) - delta_t'(p0);
			nl = delta_t'(wmax) - delta_t'(p0);
		end else begin
			ne = delta_t'(p0) - delta_t'(wmax);
			nl = delta_t'(p0) - delta_t'(wmin);
		end
		r.d   = d;
		r.rej = (d == 0) && ((p0 < wmin) || (p0 > wmax));
		r.le  = mk_lane(ne, ad);
		r.ll  = mk_lane(nl, ad);
		if (d == 0 || ne < 0) begin
			r.fe = 1'b1;
			r.ve = '0;
		end else if (ne > sad) begin
			r.fe = 1'b1;
			r.ve = T_ONE + ratio_t'(1);
		end else if (ne == sad) begin
			r.fe = 1'b1;
			r.ve = T_ONE;
		end else begin
			r.fe = 1'b0;
			r.ve = '0;
		end
		if (d == 0 || nl >= sad) begin
			r.fl = 1'b1;
			r.vl = T_ONE;
		end else if (nl < 0) begin
			r.fl = 1'b1;
			r.vl = -ratio_t'(1);
		end else begin
			r.fl = 1'b0;
			r.vl = '0;
		end
		return r;
	endfunction

	function automatic coord_t sat_c(input sum_t v);
		if (v > SAT_HI) begin
			return coord_t'(SAT_HI);
		end else if (v < SAT_LO) begin
			return coord_t'(SAT_LO);
		end
		return coord_t'(v);
	endfunction

	// flow control

	logic en_out, en_s5, en_s4, en_s3, en_s2, en_s1;
	logic r1_adv, r2_adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic out_valid_q;

	assign en_out   = !out_valid_q || !out_stall;
	assign en_s5    = !v_s5 || r2_adv;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || r1_adv;
	assign in_stall = !en_s1;

	// stage 1: edge numerators and special cases

	axis_setup_t ax_c, ay_c;
	edge_side_t  es_c;
	div_item_t   item_c;
	div_item_t   item_s1;
	div_item_t   r1_in;
	div_item_t   r1_out;

	always_comb begin
		ax_c         = axis_setup(start_x, end_x, win_left_q, win_right_q);
		ay_c         = axis_setup(start_y, end_y, win_bottom_q, win_top_q);
		es_c.x0      = start_x;
		es_c.y0      = start_y;
		es_c.dx      = ax_c.d;
		es_c.dy      = ay_c.d;
		es_c.rej     = ax_c.rej || ay_c.rej;
		es_c.frc     = {ay_c.fl, ay_c.fe, ax_c.fl, ax_c.fe};
		es_c.fval    = {ay_c.vl, ay_c.ve, ax_c.vl, ax_c.ve};
		item_c.valid = in_valid;
		item_c.lane  = {ay_c.ll, ay_c.le, ax_c.ll, ax_c.le};
		item_c.side  = es_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= item_c;
		end
	end

	always_comb begin
		r1_in       = item_s1;
		r1_in.valid = v_s1;
	end

	lcvm_div_row u_edge_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv_in  (en_s2),
		.adv_out (r1_adv),
		.d_in    (r1_in),
		.d_out   (r1_out)
	);

	// stage 2: entry and exit parameters

	edge_side_t es1_c;
	ratio_t     rr_c [NLANE];
	ratio_t     t1_c, t2_c;
	coord_t     x0_s2, y0_s2;
	delta_t     dx_s2, dy_s2;
	tpar_t      t1_s2, t2_s2;
	logic       vis_s2;

	always_comb begin
		es1_c = edge_side_t'(r1_out.side);
		for (int i = 0; i < NLANE; i++) begin
			if (es1_c.frc[i]) begin
				rr_c[i] = es1_c.fval[i];
			end else if (i[0] == 1'b0) begin
				rr_c[i] = ratio_t'(r1_out.lane[i].quo) +
					ratio_t'(r1_out.lane[i].rem != '0);
			end else begin
				rr_c[i] = ratio_t'(r1_out.lane[i].quo);
			end
		end
		t1_c = (rr_c[0] > rr_c[2]) ? rr_c[0] : rr_c[2];
		t2_c = (rr_c[1] < rr_c[3]) ? rr_c[1] : rr_c[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= r1_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			x0_s2  <= es1_c.x0;
			y0_s2  <= es1_c.y0;
			dx_s2  <= es1_c.dx;
			dy_s2  <= es1_c.dy;
			t1_s2  <= t1_c[PARAM_F:0];
			t2_s2  <= t2_c[PARAM_F:0];
			vis_s2 <= !es1_c.rej && (t1_c <= t2_c);
		end
	end

	// stage 3: parameter times direction

	prod_t  prod_s3 [NLANE];
	coord_t x0_s3, y0_s3;
	logic   vis_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3[0] <= prod_t'($signed({1'b0, t1_s2})) * prod_t'(dx_s2);
			prod_s3[1] <= prod_t'($signed({1'b0, t1_s2})) * prod_t'(dy_s2);
			prod_s3[2] <= prod_t'($signed({1'b0, t2_s2})) * prod_t'(dx_s2);
			prod_s3[3] <= prod_t'($signed({1'b0, t2_s2})) * prod_t'(dy_s2);
			x0_s3      <= x0_s2;
			y0_s3      <= y0_s2;
			vis_s3     <= vis_s2;
		end
	end

	// stage 4: clipped points, offsets into the window

	prod_t              rnd_c  [NLANE];
	delta_t             pt_c   [NLANE];
	wide_t              ofs_c  [NLANE];
	logic [COORD_W-1:0] cl_c   [NLANE];
	logic [COORD_W-1:0] a_s4   [NLANE];
	logic               vis_s4;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			rnd_c[i] = (prod_s3[i] + HALF) >>> PARAM_F;
			pt_c[i]  = delta_t'((i[0] == 1'b0) ? x0_s3 : y0_s3) + delta_t'(rnd_c[i]);
			ofs_c[i] = wide_t'(pt_c[i]) - wide_t'(wmin_a[i[0]]);
			if (ofs_c[i] < 0) begin
				cl_c[i] = '0;
			end else if (ofs_c[i] > wide_t'(ww_a[i[0]])) begin
				cl_c[i] = ww_a[i[0]][COORD_W-1:0];
			end else begin
				cl_c[i] = ofs_c[i][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			a_s4   <= cl_c;
			vis_s4 <= vis_s3;
		end
	end

	// stage 5: offset times viewport extent

	logic [2*COORD_W-1:0] n_s5 [NLANE];
	logic                 vis_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int i = 0; i < NLANE; i++) begin
				n_s5[i] <= (2*COORD_W)'(a_s4[i]) * (2*COORD_W)'(avw_a[i[0]]);
			end
			vis_s5 <= vis_s4;
		end
	end

	div_item_t r2_in;
	div_item_t r2_out;

	always_comb begin
		logic [COORD_W+DIV_STEPS-1:0] dividend;
		r2_in.valid = v_s5;
		r2_in.side  = SIDE_W'(vis_s5);
		for (int i = 0; i < NLANE; i++) begin
			dividend              = (COORD_W+DIV_STEPS)'(n_s5[i]);
			r2_in.lane[i].rem = dividend[COORD_W+DIV_STEPS-1 -: COORD_W];
			r2_in.lane[i].num = dividend[DIV_STEPS-1:0];
			r2_in.lane[i].quo = '0;
			r2_in.lane[i].dvs = ww_a[i[0]][COORD_W-1:0];
		end
	end

	lcvm_div_row u_map_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv_in  (en_out),
		.adv_out (r2_adv),
		.d_in    (r2_in),
		.d_out   (r2_out)
	);

	// output: rounding, mirroring, saturation

	sum_t   m_c   [NLANE];
	sum_t   off_c [NLANE];
	coord_t res_c [NLANE];
	logic   vis_c;
	logic   visible_q;
	coord_t res_q [NLANE];

	always_comb begin
		vis_c = r2_out.side[0];
		for (int i = 0; i < NLANE; i++) begin
			m_c[i]   = sum_t'(r2_out.lane[i].quo) +
				sum_t'({r2_out.lane[i].rem, 1'b0} >= {1'b0, r2_out.lane[i].dvs});
			off_c[i] = (vw_a[i[0]] < 0) ? -m_c[i] : m_c[i];
			if (!vis_c) begin
				res_c[i] = '0;
			end else if (ww_a[i[0]] <= 0) begin
				res_c[i] = vmin_a[i[0]];
			end else begin
				res_c[i] = sat_c(sum_t'(vmin_a[i[0]]) + off_c[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= r2_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			visible_q <= vis_c;
			res_q     <= res_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign visible      = visible_q;
	assign view_start_x = res_q[0];
	assign view_start_y = res_q[1];
	assign view_end_x   = res_q[2];
	assign view_end_y   = res_q[3];

endmodule
